// ----- hw/rtl/gde_pkg.sv -----
// Shared types and constants of the graph diffusion edge step.
// Used by the channel interfaces, the top level and the testbench.
package gde_pkg;

  localparam int NUM_BALLS_DEF = 4096;

  localparam int BALL_W    = 12;
  localparam int MASS_W    = 32;
  localparam int RAD_W     = 16;
  localparam int WEIGHT_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd1;

  // 3/(4*pi) in Q0.32
  localparam logic [29:0] INVK      = 30'd1025347913;
  localparam logic [30:0] CONC_MAX  = 31'h7FFF_FFFF;
  localparam logic [63:0] FLUX_CAP  = 64'h0000_0100_0000_0000;

endpackage

// ----- hw/rtl/gde_chan_if.sv -----
// Valid/ready channel interfaces of the graph diffusion edge step.
// Depends on gde_pkg for field widths and the command type.
interface gde_in_if;
  logic                            valid;
  logic                            ready;
  gde_pkg::cmd_t                   command;
  logic [gde_pkg::BALL_W-1:0]      first_ball;
  logic [gde_pkg::BALL_W-1:0]      second_ball;
  logic signed [gde_pkg::MASS_W-1:0] mass_in;
  logic [gde_pkg::RAD_W-1:0]       radius_in;
  logic [gde_pkg::WEIGHT_W-1:0]    edge_weight;

  modport source (output valid, command, first_ball, second_ball, mass_in, radius_in,
                  edge_weight, input ready);
  modport sink   (input valid, command, first_ball, second_ball, mass_in, radius_in,
                  edge_weight, output ready);
endinterface

interface gde_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gde_pkg::MASS_W-1:0] mass_out;
  logic                              saturated;

  modport source (output valid, mass_out, saturated, input ready);
  modport sink   (input valid, mass_out, saturated, output ready);
endinterface

interface gde_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gde_pkg::CFG_IDX_W-1:0] index;
  logic [gde_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gde_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/graph_diffusion_edge_step.sv -----
// Graph diffusion edge step: top level with sequencer, shared multiplier and divider.
// Depends on gde_pkg, the gde_*_if channel interfaces and gde_ram.
//
// Usage:
//   in_chan carries one command per transaction: load a sphere (mass into both stores,
//   radius into the current store), apply an edge (move flux between two pending
//   masses), commit a sphere (pending mass to current mass) or read a sphere.
//   Only a read produces out_chan output: the current mass and sticky saturation flag.
//   cfg_chan writes diffusion_coeff (index 0) and time_step (index 1); it is always
//   ready and must only be used while the block is idle.
// Operation (one command at a time): load writes both stores as it is accepted;
//   commit goes through cmt_r to the current store, read through resp_r to the
//   output register. An edge is dominated by two concentrations through a bit-serial
//   divider (31 steps each, skipped for a zero radius) and a multiply chain on one
//   shared 32x32 multiplier, then two read-modify-writes of the pending store.
// Reset clears the sequencer, the output valid bit, the flag and both config
//   registers; the stores are undefined until loaded.
// A stalled receiver holds the result in the output register; the block keeps
//   taking commands and only waits when a second read result is ready.
module graph_diffusion_edge_step #(
  parameter int NUM_BALLS = gde_pkg::NUM_BALLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gde_in_if.sink    in_chan,
  gde_out_if.source out_chan,
  gde_cfg_if.sink   cfg_chan
);

  localparam int AW    = (NUM_BALLS > 2) ? $clog2(NUM_BALLS) : 1;
  localparam int CUR_W = gde_pkg::MASS_W + gde_pkg::RAD_W;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'd1,
    ST_RDB   = 18'd2,
    ST_CAPB  = 18'd4,
    ST_R2    = 18'd8,
    ST_R3    = 18'd16,
    ST_NUM   = 18'd32,
    ST_DIVI  = 18'd64,
    ST_DIV   = 18'd128,
    ST_CDONE = 18'd256,
    ST_P     = 18'd512,
    ST_TLO   = 18'd1024,
    ST_THI   = 18'd2048,
    ST_T     = 18'd4096,
    ST_FLO   = 18'd8192,
    ST_FHI   = 18'd16384,
    ST_F     = 18'd32768,
    ST_UPA   = 18'd65536,
    ST_UPB   = 18'd131072
  } state_t;

  // commit and read reuse the short path through the idle state; they get their own codes
  // folded into the edge sequence would obscure it, so keep two extra flags instead
  state_t state_r, state_nxt;
  logic   cmt_r, cmt_nxt;     // commit write pending
  logic   resp_r, resp_nxt;   // read result pending

  // configuration
  logic [31:0] coeff_r, step_r;

  // item registers
  logic [AW-1:0] a_addr_r, b_addr_r;
  logic [31:0]   w_r;
  logic          inrange_r;

  // concentration path
  logic signed [31:0] ma_r, mb_r;
  logic [15:0]        ra_r, rb_r;
  logic               sel_b_r;
  logic [63:0]        prod_r;
  logic [47:0]        r3_r;
  logic [56:0]        rem_r;
  logic [30:0]        numlo_r;
  logic [30:0]        q_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] ca_r, cb_r;

  // flux path
  logic [31:0]        dmag_r;
  logic               dneg_r;
  logic [63:0]        p_r;
  logic [63:0]        acc_r;
  logic [59:0]        t_r;
  logic signed [41:0] flux_r;

  logic sat_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_mass_r;
  logic               out_sat_r;

  // memories
  logic             cur_we, cur_re, pend_we, pend_re;
  logic [AW-1:0]    cur_waddr, cur_raddr, pend_waddr, pend_raddr;
  logic [CUR_W-1:0] cur_wdata, cur_rdata;
  logic [31:0]      pend_wdata, pend_rdata;

  // combinational helpers
  logic        in_fire, out_load;
  logic [31:0] a_ext, b_ext;
  logic        a_ok, b_ok;
  logic [AW-1:0] a_in, b_in;
  logic signed [31:0] m_sel;
  logic [15:0] r_sel;
  logic [31:0] mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] num;
  logic [55:0] den;
  logic [56:0] div_sh;
  logic        div_ge;
  logic signed [32:0] dval;
  logic [95:0] tsum, fsum;
  logic [63:0] fq;
  logic [40:0] fmag;
  logic signed [42:0] upd_a, upd_b;
  logic signed [31:0] sat_a, sat_b;
  logic        ovf_a, ovf_b;

  function automatic logic signed [31:0] clip32(input logic signed [42:0] v);
    logic hi, lo;
    hi = !v[42] && (|v[41:31]);
    lo = v[42] && !(&v[41:31]);
    if (hi) begin
      clip32 = 32'sh7FFF_FFFF;
    end else if (lo) begin
      clip32 = 32'sh8000_0000;
    end else begin
      clip32 = v[31:0];
    end
  endfunction

  function automatic logic clipped(input logic signed [42:0] v);
    clipped = (!v[42] && (|v[41:31])) || (v[42] && !(&v[41:31]));
  endfunction

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && !cmt_r && !resp_r;
  assign cfg_chan.ready = 1'b1;

  assign a_ext = 32'(in_chan.first_ball);
  assign b_ext = 32'(in_chan.second_ball);
  assign a_ok  = a_ext < 32'(NUM_BALLS);
  assign b_ok  = b_ext < 32'(NUM_BALLS);
  assign a_in  = a_ext[AW-1:0];
  assign b_in  = b_ext[AW-1:0];

  // select the sphere whose concentration is being worked out
  assign m_sel = sel_b_r ? mb_r : ma_r;
  assign r_sel = sel_b_r ? rb_r : ra_r;
  assign mag   = m_sel[31] ? (~m_sel + 32'd1) : m_sel;

  // shared multiplier: operands chosen by the sequencer, product always registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_R2:   begin mul_a = {16'd0, r_sel};  mul_b = {16'd0, r_sel}; end
      ST_R3:   begin mul_a = prod_r[31:0];    mul_b = {16'd0, r_sel}; end
      ST_NUM:  begin mul_a = mag;             mul_b = {2'd0, gde_pkg::INVK}; end
      ST_P:    begin mul_a = coeff_r;         mul_b = step_r; end
      ST_TLO:  begin mul_a = prod_r[31:0];    mul_b = w_r; end
      ST_THI:  begin mul_a = p_r[63:32];      mul_b = w_r; end
      ST_FLO:  begin mul_a = t_r[31:0];       mul_b = dmag_r; end
      ST_FHI:  begin mul_a = {4'd0, t_r[59:32]}; mul_b = dmag_r; end
      default: begin mul_a = '0;              mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operands: numerator carries the half-divisor for rounding
  assign num    = prod_r + {9'd0, r3_r, 7'd0};
  assign den    = {r3_r, 8'd0};
  assign div_sh = {rem_r[55:0], numlo_r[30]};
  assign div_ge = div_sh >= {1'b0, den};

  assign dval = {ca_r[31], ca_r} - {cb_r[31], cb_r};

  assign tsum = {prod_r, 32'd0} + {32'd0, acc_r} + 96'h8_0000_0000;
  assign fsum = {prod_r, 32'd0} + {32'd0, acc_r} + 96'h8000_0000;
  assign fq   = fsum[95:32];
  assign fmag = (fq > gde_pkg::FLUX_CAP) ? gde_pkg::FLUX_CAP[40:0] : fq[40:0];

  // pending updates: subtract at the first end, add at the second
  assign upd_a = {{11{pend_rdata[31]}}, pend_rdata} - {flux_r[41], flux_r};
  assign upd_b = {{11{pend_rdata[31]}}, pend_rdata} + {flux_r[41], flux_r};
  assign sat_a = clip32(upd_a);
  assign sat_b = clip32(upd_b);
  assign ovf_a = clipped(upd_a);
  assign ovf_b = clipped(upd_b);

  assign out_load = resp_r && (!out_valid_r || out_chan.ready);

  // sequencer and memory control
  always_comb begin
    state_nxt  = state_r;
    cmt_nxt    = 1'b0;
    resp_nxt   = resp_r && !out_load;
    cur_we     = 1'b0;
    cur_re     = 1'b0;
    pend_we    = 1'b0;
    pend_re    = 1'b0;
    cur_waddr  = a_addr_r;
    cur_raddr  = a_in;
    pend_waddr = a_addr_r;
    pend_raddr = a_addr_r;
    cur_wdata  = {pend_rdata, cur_rdata[15:0]};
    pend_wdata = sat_a;
    if (cmt_r) begin
      // commit: keep the radius, take the pending mass
      cur_we = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.command)
            gde_pkg::CMD_LOAD: begin
              cur_we     = a_ok;
              pend_we    = a_ok;
              cur_waddr  = a_in;
              pend_waddr = a_in;
              cur_wdata  = {in_chan.mass_in, in_chan.radius_in};
              pend_wdata = in_chan.mass_in;
            end
            gde_pkg::CMD_EDGE: begin
              if (a_ok && b_ok) begin
                cur_re    = 1'b1;
                state_nxt = ST_RDB;
              end
            end
            gde_pkg::CMD_COMMIT: begin
              cur_re     = a_ok;
              pend_re    = a_ok;
              pend_raddr = a_in;
              cmt_nxt    = a_ok;
            end
            gde_pkg::CMD_READ: begin
              cur_re   = 1'b1;
              resp_nxt = 1'b1;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RDB: begin
        cur_re    = 1'b1;
        cur_raddr = b_addr_r;
        state_nxt = ST_CAPB;
      end
      ST_CAPB:  state_nxt = ST_R2;
      ST_R2:    state_nxt = ST_R3;
      ST_R3:    state_nxt = ST_NUM;
      ST_NUM:   state_nxt = ST_DIVI;
      ST_DIVI: begin
        if (r3_r == '0 || {23'd0, num[63:31]} >= den) begin
          state_nxt = ST_CDONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 5'd1) begin
          state_nxt = ST_CDONE;
        end
      end
      ST_CDONE: state_nxt = sel_b_r ? ST_P : ST_R2;
      ST_P:     state_nxt = ST_TLO;
      ST_TLO:   state_nxt = ST_THI;
      ST_THI:   state_nxt = ST_T;
      ST_T:     state_nxt = ST_FLO;
      ST_FLO:   state_nxt = ST_FHI;
      ST_FHI:   state_nxt = ST_F;
      ST_F: begin
        pend_re   = 1'b1;
        state_nxt = ST_UPA;
      end
      ST_UPA: begin
        // a self edge reads the old value here, but its flux is zero
        pend_we    = 1'b1;
        pend_re    = 1'b1;
        pend_raddr = b_addr_r;
        state_nxt  = ST_UPB;
      end
      ST_UPB: begin
        pend_we    = 1'b1;
        pend_waddr = b_addr_r;
        pend_wdata = sat_b;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmt_r       <= 1'b0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      coeff_r     <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cmt_r       <= cmt_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
      if ((state_r == ST_UPA && ovf_a) || (state_r == ST_UPB && ovf_b)) begin
        sat_r <= 1'b1;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == gde_pkg::REG_COEFF) begin
          coeff_r <= cfg_chan.data;
        end else if (cfg_chan.index == gde_pkg::REG_STEP) begin
          step_r <= cfg_chan.data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (in_fire) begin
      a_addr_r  <= a_in;
      b_addr_r  <= b_in;
      w_r       <= in_chan.edge_weight;
      inrange_r <= a_ok;
    end
    if (out_load) begin
      out_mass_r <= inrange_r ? cur_rdata[CUR_W-1:16] : '0;
      out_sat_r  <= sat_r;
    end
    case (state_r)
      ST_RDB: begin
        ma_r <= cur_rdata[CUR_W-1:16];
        ra_r <= cur_rdata[15:0];
      end
      ST_CAPB: begin
        mb_r    <= cur_rdata[CUR_W-1:16];
        rb_r    <= cur_rdata[15:0];
        sel_b_r <= 1'b0;
      end
      ST_NUM: r3_r <= prod_r[47:0];
      ST_DIVI: begin
        // zero radius gives zero concentration; a quotient past 31 bits clamps
        if (r3_r == '0) begin
          q_r <= '0;
        end else if ({23'd0, num[63:31]} >= den) begin
          q_r <= gde_pkg::CONC_MAX;
        end else begin
          q_r <= '0;
        end
        rem_r   <= {24'd0, num[63:31]};
        numlo_r <= num[30:0];
        cnt_r   <= 5'd31;
      end
      ST_DIV: begin
        rem_r   <= div_ge ? (div_sh - {1'b0, den}) : div_sh;
        q_r     <= {q_r[29:0], div_ge};
        numlo_r <= {numlo_r[29:0], 1'b0};
        cnt_r   <= cnt_r - 5'd1;
      end
      ST_CDONE: begin
        if (sel_b_r) begin
          cb_r <= m_sel[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
        end else begin
          ca_r    <= m_sel[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          sel_b_r <= 1'b1;
        end
      end
      ST_P: begin
        dneg_r <= dval[32];
        dmag_r <= dval[32] ? 32'(-dval) : dval[31:0];
      end
      ST_TLO: p_r   <= prod_r;
      ST_THI: acc_r <= prod_r;
      ST_T:   t_r   <= tsum[95:36];
      ST_FHI: acc_r <= prod_r;
      ST_F: begin
        flux_r <= dneg_r ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
      end
      default: begin
        sel_b_r <= sel_b_r;
      end
    endcase
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.mass_out  = out_mass_r;
  assign out_chan.saturated = out_sat_r;

  gde_ram #(.WIDTH(CUR_W), .DEPTH(NUM_BALLS)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  gde_ram #(.WIDTH(gde_pkg::MASS_W), .DEPTH(NUM_BALLS)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  // a new result appears only after a read was dispatched
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(resp_r))
    else $error("result without a pending read");

  // the second pending update always follows the first
  a_upb_after_upa: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPB) |-> $past(state_r == ST_UPA))
    else $error("pending update order broken");

  // the saturation flag is sticky
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |=> sat_r)
    else $error("saturation flag cleared");

  // both stores are written together only by a load
  a_dual_write_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_we && pend_we) |-> (state_r == ST_IDLE && in_fire))
    else $error("unexpected dual store write");

  // no command is taken while a commit or a read is still in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmt_r || resp_r) |-> !in_chan.ready)
    else $error("accepted during commit or read");

endmodule

// ----- test/tb_graph_diffusion_edge_step.sv -----
// Self-checking testbench for graph_diffusion_edge_step: directed and random commands,
// with a bit-exact fixed-point predictor of the diffusion step inside a scoreboard class.
// Depends on gde_pkg, the gde_*_if channel interfaces and the block's RTL.
module tb_graph_diffusion_edge_step;

  localparam int          NBALLS     = 4096;
  localparam int          CYCLE_CAP  = 2_000_000;
  localparam int          DRAIN_WAIT = 200;
  localparam logic [63:0] RD_HALF36  = 64'h8_0000_0000;

  // Predicts read results from the accepted command stream and checks them in order.
  class diffusion_scoreboard;
    logic signed [31:0] cur_mass [NBALLS];
    logic signed [31:0] pend_mass [NBALLS];
    logic [15:0]        radius [NBALLS];
    logic [31:0]        coeff, dt;
    bit                 sat_flag;
    logic [32:0]        read_q [$];  // {saturated, mass}
    int                 errors;

    function new();
      coeff = '0;
      dt = '0;
      sat_flag = 0;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
    endtask

    function void set_reg(logic [gde_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == gde_pkg::REG_COEFF) coeff = val;
      else if (idx == gde_pkg::REG_STEP) dt = val;
    endfunction

    // Q8.24 concentration: mass / (4/3 pi r^3), zero for a zero radius.
    function logic signed [63:0] concentration(int k);
      logic [127:0] r, r3, den, mag, q;
      r = 128'(radius[k]);
      r3 = r * r * r;
      if (r3 == 0) return 0;
      mag = cur_mass[k] < 0 ? 128'(-64'(cur_mass[k])) : 128'(cur_mass[k]);
      den = r3 << 8;
      q = (mag * 128'(32'd1025347913) + (den >> 1)) / den;
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return cur_mass[k] < 0 ? -64'(q) : 64'(q);
    endfunction

    function void add_pending(int k, logic signed [63:0] delta);
      logic signed [63:0] v;
      v = 64'(pend_mass[k]) + delta;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        sat_flag = 1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        sat_flag = 1;
      end
      pend_mass[k] = v[31:0];
    endfunction

    function void note(gde_pkg::cmd_t c, int a, int b, logic [31:0] m, logic [15:0] r,
                       logic [31:0] w);
      logic signed [63:0] d, flux;
      logic [127:0] p, t, f;
      logic [63:0] dmag;
      case (c)
        gde_pkg::CMD_LOAD: begin
          cur_mass[a] = m;
          pend_mass[a] = m;
          radius[a] = r;
        end
        gde_pkg::CMD_EDGE: begin
          d = concentration(a) - concentration(b);
          dmag = d < 0 ? -d : d;
          p = 128'(coeff) * 128'(dt);
          t = (p * 128'(w) + 128'(RD_HALF36)) >> 36;
          if (t > 128'hFFFF_FFFF_FFFF_FFFF) t = 128'hFFFF_FFFF_FFFF_FFFF;
          f = (t * 128'(dmag) + 128'h8000_0000) >> 32;
          if (f > 128'(gde_pkg::FLUX_CAP)) f = 128'(gde_pkg::FLUX_CAP);
          flux = d < 0 ? -64'(f) : 64'(f);
          add_pending(a, -flux);
          add_pending(b, flux);
        end
        gde_pkg::CMD_COMMIT: cur_mass[a] = pend_mass[a];
        gde_pkg::CMD_READ: read_q.push_back({sat_flag, cur_mass[a]});
        default: ;
      endcase
    endfunction

    task check(logic [31:0] mass, logic sat);
      logic [32:0] want;
      if (read_q.size() == 0) begin
        report("unexpected read result", mass, 32'd0);
        return;
      end
      want = read_q.pop_front();
      if (mass !== want[31:0]) report("mass_out", mass, want[31:0]);
      if (sat !== want[32]) report("saturated", 32'(sat), 32'(want[32]));
    endtask
  endclass

  logic clk, rst_n;
  gde_in_if  in_if ();
  gde_out_if out_if ();
  gde_cfg_if cfg_if ();

  graph_diffusion_edge_step DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if), .cfg_chan(cfg_if)
  );

  diffusion_scoreboard sb = new();
  int  send_idle, recv_idle;
  logic rx_hold;
  int  cycles = 0;
  bit  loaded [NBALLS];
  int  loaded_list [$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_graph_diffusion_edge_step: errors");
      $finish;
    end
  end

  // Receiver: random back-pressure, forced low during a long hold.
  always @(posedge clk) begin
    if (rx_hold) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Check every read transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check(out_if.mass_out, out_if.saturated);
  end

  task automatic send(gde_pkg::cmd_t c, int a, int b, logic [31:0] m, logic [15:0] r,
                      logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= c;
    in_if.first_ball  <= a[11:0];
    in_if.second_ball <= b[11:0];
    in_if.mass_in     <= m;
    in_if.radius_in   <= r;
    in_if.edge_weight <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note(c, a, b, m, r, w);
    if (c == gde_pkg::CMD_LOAD && !loaded[a]) begin
      loaded[a] = 1;
      loaded_list.push_back(a);
    end
  endtask

  task automatic write_reg(logic [gde_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop input valid, drain every pending read, then let a trailing edge finish.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.read_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // One random command; spheres used by edge, commit and read are always loaded.
  task automatic random_item();
    int sel, a, b;
    logic [31:0] m, w;
    logic [15:0] r;
    sel = $urandom_range(99);
    a = pick_loaded();
    b = pick_loaded();
    m = $urandom();
    if ($urandom_range(1)) m = $signed(m) >>> $urandom_range(31);
    case ($urandom_range(3))
      0: r = 16'd0;
      1: r = 16'($urandom_range(16'h0400));
      default: r = 16'($urandom());
    endcase
    w = $urandom() >> $urandom_range(31);
    if (sel < 20) begin
      a = $urandom_range(1) ? $urandom_range(NBALLS - 1) : $urandom_range(63);
      send(gde_pkg::CMD_LOAD, a, $urandom_range(NBALLS - 1), m, r, w);
    end else if (sel < 65) begin
      if ($urandom_range(19) == 0) b = a;
      send(gde_pkg::CMD_EDGE, a, b, m, r, w);
    end else if (sel < 80) begin
      send(gde_pkg::CMD_COMMIT, a, $urandom_range(NBALLS - 1), m, r, w);
    end else begin
      send(gde_pkg::CMD_READ, a, $urandom_range(NBALLS - 1), m, r, w);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= gde_pkg::CMD_LOAD;
    in_if.first_ball <= '0;
    in_if.second_ball <= '0;
    in_if.mass_in <= '0;
    in_if.radius_in <= '0;
    in_if.edge_weight <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= gde_pkg::REG_COEFF;
    cfg_if.data <= '0;
    rx_hold <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficient 1.0, time step 0.5.
    write_reg(gde_pkg::REG_COEFF, 32'h0000_1000);
    write_reg(gde_pkg::REG_STEP, 32'h8000_0000);

    // Directed: extreme masses and radii, self edge, zero-radius ends, saturation.
    send(gde_pkg::CMD_LOAD, 0, 4095, 32'h7FFF_FFFF, 16'h0100, 32'hFFFF_FFFF);
    send(gde_pkg::CMD_LOAD, 1, 0, 32'h8000_0000, 16'h0100, 32'h0);
    send(gde_pkg::CMD_LOAD, 4095, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_LOAD, 2, 0, 32'h1, 16'hFFFF, 32'h0);
    send(gde_pkg::CMD_LOAD, 3, 0, 32'hFFFF_0000, 16'h0001, 32'h0);
    send(gde_pkg::CMD_READ, 0, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_EDGE, 2, 2, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send(gde_pkg::CMD_EDGE, 4095, 3, 32'h0, 16'h0, 32'h0100_0000);
    send(gde_pkg::CMD_EDGE, 3, 4095, 32'h0, 16'h0, 32'h0000_0001);
    send(gde_pkg::CMD_EDGE, 2, 4095, 32'h0, 16'h0, 32'h0100_0000);
    send(gde_pkg::CMD_COMMIT, 3, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_READ, 3, 4095, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_READ, 2, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_EDGE, 0, 1, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send(gde_pkg::CMD_COMMIT, 0, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_COMMIT, 1, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_READ, 0, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_READ, 1, 0, 32'h0, 16'h0, 32'h0);
    send(gde_pkg::CMD_READ, 4095, 0, 32'h0, 16'h0, 32'h0);

    // Random phases, each with its own idling pattern and register setting.
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          send_idle = 31;
          recv_idle = 83;
          write_reg(gde_pkg::REG_COEFF, $urandom());
          write_reg(gde_pkg::REG_STEP, $urandom());
        end
        1: begin
          send_idle = 83;
          recv_idle = 31;
          write_reg(gde_pkg::REG_COEFF, 32'hFFFF_FFFF);
          write_reg(gde_pkg::REG_STEP, 32'hFFFF_FFFF);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(gde_pkg::REG_COEFF, 32'h0);
          write_reg(gde_pkg::REG_STEP, $urandom() >> $urandom_range(31));
        end
      endcase
      if (ph == 0) begin
        // Hold the receiver for a long stretch while reads keep coming.
        fork
          begin
            rx_hold <= 1'b1;
            repeat (600) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
        repeat (40) send(gde_pkg::CMD_READ, pick_loaded(), $urandom_range(NBALLS - 1),
                         $urandom(), 16'($urandom()), $urandom());
      end
      repeat (600) random_item();
    end

    wait_idle();
    if (sb.errors == 0)
      $display("tb_graph_diffusion_edge_step: clean");
    else
      $display("tb_graph_diffusion_edge_step: errors");
    $finish;
  end
endmodule
